// ===== rtl/rtdec_pkg.sv =====
// Shared constants, result kind codes and divider request/response types
// for the fraction to repeating decimal core. No dependencies.
package rtdec_pkg;

  localparam int DIGITS   = 20;
  localparam int DATA_W   = 16;
  localparam int DIG_W    = 4;
  localparam int ENTRY_W  = DATA_W + DIG_W;
  localparam int CNT_W    = $clog2(DIGITS + 1);
  localparam int ADDR_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int STEP_W   = 5;
  localparam int KIND_W   = 2;

  localparam logic [STEP_W-1:0] INT_STEPS = STEP_W'(DATA_W);
  localparam logic [STEP_W-1:0] DIG_STEPS = STEP_W'(DIG_W);

  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_INT    = 2'd0;
  localparam kind_t KIND_NONREP = 2'd1;
  localparam kind_t KIND_REP    = 2'd2;
  localparam kind_t KIND_ERR    = 2'd3;

  // start a restoring division: remainder seed, dividend bits MSB first
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] rem_init;
    logic [DATA_W-1:0] bits;
    logic [STEP_W-1:0] steps;
    logic [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== rtl/rtdec_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module rtdec_ram #(
  parameter int WIDTH  = 20,
  parameter int DEPTH  = 20,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rtdec_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on rtdec_pkg for widths and the request/response structs.
module rtdec_div (
  input  logic                clk,
  input  logic                rst_n,
  input  rtdec_pkg::div_req_t req,
  output rtdec_pkg::div_rsp_t rsp
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [rtdec_pkg::DATA_W-1:0]   rem_r, rem_nxt;
  logic [rtdec_pkg::DATA_W-1:0]   bits_r, bits_nxt;
  logic [rtdec_pkg::DATA_W-1:0]   quo_r, quo_nxt;
  logic [rtdec_pkg::DATA_W-1:0]   den_r, den_nxt;
  logic [rtdec_pkg::STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [rtdec_pkg::DATA_W:0]     trial;
  logic [rtdec_pkg::DATA_W:0]     diff;
  logic                           qbit;

  assign trial = {rem_r, bits_r[rtdec_pkg::DATA_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign qbit  = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    bits_nxt = bits_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      rem_nxt  = req.rem_init;
      bits_nxt = req.bits;
      quo_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = req.steps;
    end else if (busy_r) begin
      rem_nxt  = qbit ? diff[rtdec_pkg::DATA_W-1:0] : trial[rtdec_pkg::DATA_W-1:0];
      bits_nxt = {bits_r[rtdec_pkg::DATA_W-2:0], 1'b0};
      quo_nxt  = {quo_r[rtdec_pkg::DATA_W-2:0], qbit};
      cnt_nxt  = cnt_r - rtdec_pkg::STEP_W'(1);
      if (cnt_r == rtdec_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    bits_r <= bits_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== rtl/fraction_to_repeating_decimal_core.sv =====
// Fraction to repeating decimal core: each request N/D returns the integer
// quotient, then up to 20 fraction digits tagged non-repeating or repeating;
// a zero denominator returns one error result. One fraction is in work at a
// time. The integer division runs on the shared bit-serial divider. For
// fraction digit k (from 0) the history memory's single read port scans the
// k stored remainders one per cycle, then a 4-step division forms the digit.
// Results then leave at one per cycle when the output side is ready; the
// next request is taken as soon as the last result sits in the output
// register. Depends on rtdec_pkg, rtdec_div and rtdec_ram.
module fraction_to_repeating_decimal_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] numerator, [31:16] denominator
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] value
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast
);

  typedef enum logic [2:0] {
    S_IDLE, S_ERR, S_IDIV, S_CHECK, S_SCAN, S_DDIV, S_EINT, S_EOUT
  } state_t;

  localparam int CW = rtdec_pkg::CNT_W;
  localparam int AW = rtdec_pkg::ADDR_W;
  localparam int DW = rtdec_pkg::DATA_W;

  state_t                 state_r, state_nxt;
  logic [DW-1:0]          quo_r, quo_nxt;
  logic [DW-1:0]          r_r, r_nxt;
  logic [DW-1:0]          den_r, den_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [CW-1:0]          cs_r, cs_nxt;
  logic [CW-1:0]          j_r, j_nxt;
  logic [CW-1:0]          ri_r, ri_nxt;
  logic                   rv_r, rv_nxt;
  logic [CW-1:0]          e_r, e_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [DW-1:0]          out_value_r, out_value_nxt;
  rtdec_pkg::kind_t       out_kind_r, out_kind_nxt;
  logic                   out_last_r, out_last_nxt;

  rtdec_pkg::div_req_t    div_req;
  rtdec_pkg::div_rsp_t    div_rsp;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [rtdec_pkg::ENTRY_W-1:0] mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;
  logic [rtdec_pkg::ENTRY_W-1:0] mem_rdata;

  logic                   slot_free;
  logic                   hit;
  logic [CW-1:0]          e_inc;
  logic                   is_last;
  logic [DW+3:0]          ten_rem;
  logic [DW-1:0]          in_num;
  logic [DW-1:0]          in_den;

  assign in_num    = in_tdata[15:0];
  assign in_den    = in_tdata[31:16];
  assign slot_free = !out_valid_r || out_tready;
  assign hit       = rv_r && (mem_rdata[rtdec_pkg::ENTRY_W-1:rtdec_pkg::DIG_W] == r_r);
  assign e_inc     = e_r + CW'(1);
  assign is_last   = (e_inc == cnt_r);
  // 10 * r as 8r + 2r
  assign ten_rem   = {1'b0, r_r, 3'b000} + {3'b000, r_r, 1'b0};
  assign in_tready = (state_r == S_IDLE);

  // history memory: remainder in the upper bits, digit in the lower bits
  rtdec_ram #(
    .WIDTH (rtdec_pkg::ENTRY_W),
    .DEPTH (rtdec_pkg::DIGITS),
    .ADDR_W(AW)
  ) u_hist (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  rtdec_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign mem_we    = (state_r == S_DDIV) && div_rsp.done;
  assign mem_waddr = cnt_r[AW-1:0];
  assign mem_wdata = {r_r, div_rsp.quo[rtdec_pkg::DIG_W-1:0]};

  always_comb begin
    state_nxt     = state_r;
    quo_nxt       = quo_r;
    r_nxt         = r_r;
    den_nxt       = den_r;
    cnt_nxt       = cnt_r;
    cs_nxt        = cs_r;
    j_nxt         = j_r;
    ri_nxt        = ri_r;
    rv_nxt        = 1'b0;
    e_nxt         = e_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_value_nxt = out_value_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    div_req       = '0;
    div_req.den   = den_r;
    mem_re        = 1'b0;
    mem_raddr     = j_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          den_nxt = in_den;
          if (in_den == '0) begin
            state_nxt = S_ERR;
          end else begin
            div_req.start    = 1'b1;
            div_req.rem_init = '0;
            div_req.bits     = in_num;
            div_req.steps    = rtdec_pkg::INT_STEPS;
            div_req.den      = in_den;
            state_nxt        = S_IDIV;
          end
        end
      end
      S_ERR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          out_kind_nxt  = rtdec_pkg::KIND_ERR;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_IDIV: begin
        if (div_rsp.done) begin
          quo_nxt   = div_rsp.quo;
          r_nxt     = div_rsp.rem;
          cnt_nxt   = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (r_r == '0) begin
          cs_nxt    = cnt_r;
          state_nxt = S_EINT;
        end else begin
          j_nxt     = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // compare the previous read while issuing the next one
        if (hit) begin
          cs_nxt    = ri_r;
          state_nxt = S_EINT;
        end else if (j_r == cnt_r) begin
          if (cnt_r == CW'(rtdec_pkg::DIGITS)) begin
            cs_nxt    = cnt_r;
            state_nxt = S_EINT;
          end else begin
            div_req.start    = 1'b1;
            div_req.rem_init = ten_rem[DW+3:4];
            div_req.bits     = {ten_rem[3:0], {(DW-4){1'b0}}};
            div_req.steps    = rtdec_pkg::DIG_STEPS;
            state_nxt        = S_DDIV;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = j_r[AW-1:0];
          ri_nxt    = j_r;
          rv_nxt    = 1'b1;
          j_nxt     = j_r + CW'(1);
        end
      end
      S_DDIV: begin
        if (div_rsp.done) begin
          r_nxt     = div_rsp.rem;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_CHECK;
        end
      end
      S_EINT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = quo_r;
          out_kind_nxt  = rtdec_pkg::KIND_INT;
          out_last_nxt  = (cnt_r == '0);
          if (cnt_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            e_nxt     = '0;
            mem_re    = 1'b1;
            mem_raddr = '0;
            state_nxt = S_EOUT;
          end
        end
      end
      S_EOUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = {{(DW-rtdec_pkg::DIG_W){1'b0}},
                           mem_rdata[rtdec_pkg::DIG_W-1:0]};
          out_kind_nxt  = (e_r >= cs_r) ? rtdec_pkg::KIND_REP : rtdec_pkg::KIND_NONREP;
          out_last_nxt  = is_last;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            e_nxt     = e_inc;
            mem_re    = 1'b1;
            mem_raddr = e_inc[AW-1:0];
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    quo_r       <= quo_nxt;
    r_r         <= r_nxt;
    den_r       <= den_nxt;
    cs_r        <= cs_nxt;
    j_r         <= j_nxt;
    ri_r        <= ri_nxt;
    e_r         <= e_nxt;
    out_value_r <= out_value_nxt;
    out_kind_r  <= out_kind_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (cnt_r <= CW'(rtdec_pkg::DIGITS)))
    else $error("digit count beyond buffer depth");

  a_div_done_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_IDIV || state_r == S_DDIV))
    else $error("divider finished outside a division state");

  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ERR && slot_free) |=> (out_valid_r && out_kind_r == rtdec_pkg::KIND_ERR
                                         && out_last_r))
    else $error("zero denominator did not produce an error result");

  a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && rv_r) |-> (ri_r < cnt_r))
    else $error("history compare on an entry not yet written");

endmodule

// ===== tb/sv/tb_fraction_to_repeating_decimal_core.sv =====
// Testbench for fraction_to_repeating_decimal_core: directed and random fractions
// checked field by field against a long-division predictor kept in this file.
// Depends on rtdec_pkg and the core RTL only.
module tb_fraction_to_repeating_decimal_core;

  localparam int HOLD_CYCLES  = 2000;
  localparam int DRAIN_CYCLES = 500;

  typedef struct {
    rtdec_pkg::kind_t kind;
    logic [15:0]      value;
    logic             last;
  } dec_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  fraction_to_repeating_decimal_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  dec_result_t expected_digits[$];
  int          error_count   = 0;
  bit          idle_en       = 1'b1;
  bit          hold_off_req  = 1'b0;

  // long-division state for the fraction being predicted
  logic [15:0] rem_seen   [rtdec_pkg::DIGITS];
  logic [3:0]  digit_seen [rtdec_pkg::DIGITS];
  int unsigned digit_total;
  int unsigned repeat_from;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb_fraction_to_repeating_decimal_core: errors");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Expand num/den and queue the integer part, then each fraction digit; a zero denominator queues one error result.
  function automatic void expand_fraction(input logic [15:0] num, input logic [15:0] den);
    int unsigned rem;
    int unsigned hit;
    bit          cyc;
    dec_result_t res;
    if (den == 16'd0) begin
      res.kind  = rtdec_pkg::KIND_ERR;
      res.value = '0;
      res.last  = 1'b1;
      expected_digits.push_back(res);
      return;
    end
    rem         = num % den;
    digit_total = 0;
    repeat_from = 0;
    cyc         = 1'b0;
    while (rem != 0) begin
      hit = digit_total;
      for (int j = 0; j < digit_total; j++) begin
        if (rem_seen[j] == rem && hit == digit_total) hit = j;
      end
      if (hit < digit_total) begin
        repeat_from = hit;
        cyc         = 1'b1;
        break;
      end
      if (digit_total >= rtdec_pkg::DIGITS) break;
      rem_seen[digit_total]   = rem[15:0];
      rem                     = rem * 10;
      digit_seen[digit_total] = 4'(rem / den);
      rem                     = rem % den;
      digit_total++;
    end
    if (!cyc) repeat_from = digit_total;
    res.kind  = rtdec_pkg::KIND_INT;
    res.value = num / den;
    res.last  = (digit_total == 0);
    expected_digits.push_back(res);
    for (int i = 0; i < digit_total; i++) begin
      res.kind  = (i >= repeat_from) ? rtdec_pkg::KIND_REP : rtdec_pkg::KIND_NONREP;
      res.value = 16'(digit_seen[i]);
      res.last  = (i + 1 == digit_total);
      expected_digits.push_back(res);
    end
  endfunction

  // Offer one request, wait for the handshake, then queue its results.
  task automatic send_fraction(input logic [15:0] num, input logic [15:0] den);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {den, num};
    do @(posedge clk); while (!in_tready);
    expand_fraction(num, den);
  endtask

  // Receiver: random ready bursts, plus one long hold-off on request.
  initial begin
    int n;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  initial begin
    dec_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (expected_digits.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d value %0d last %0b",
                                    out_tuser, out_tdata, out_tlast));
        end else begin
          want = expected_digits.pop_front();
          if (out_tuser !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", out_tuser, want.kind));
          if (out_tdata !== want.value)
            report_mismatch($sformatf("value %0d, want %0d", out_tdata, want.value));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", out_tlast, want.last));
        end
      end
    end
  end

  // Exact quotients, operand extremes, zero denominators, terminating fractions.
  task automatic test_edge_operands();
    send_fraction(16'd0, 16'd1);
    send_fraction(16'd65535, 16'd1);
    send_fraction(16'd65535, 16'd65535);
    send_fraction(16'd0, 16'd65535);
    send_fraction(16'd1, 16'd65535);
    send_fraction(16'd65534, 16'd65535);
    send_fraction(16'd0, 16'd0);
    send_fraction(16'd65535, 16'd0);
    send_fraction(16'd12345, 16'd0);
    send_fraction(16'd5, 16'd2);
    send_fraction(16'd1, 16'd8);
    send_fraction(16'd65535, 16'd2);
  endtask

  // Pure and mixed cycles, a cycle closing right at the digit limit, cutoffs.
  task automatic test_repetends();
    send_fraction(16'd1, 16'd3);
    send_fraction(16'd1, 16'd6);
    send_fraction(16'd7, 16'd12);
    send_fraction(16'd1, 16'd7);
    send_fraction(16'd22, 16'd7);
    send_fraction(16'd1, 16'd81);
    send_fraction(16'd1, 16'd17);
    send_fraction(16'd1, 16'd19);
    send_fraction(16'd1, 16'd76);
    send_fraction(16'd3, 16'd272);
    send_fraction(16'd1, 16'd97);
    send_fraction(16'd40000, 16'd9999);
  endtask

  task automatic test_random_fractions(input int count, input bit idling);
    logic [15:0] num;
    logic [15:0] den;
    int          p;
    idle_en = idling;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0:          den = '0;
        1, 2, 3, 4: den = 16'($urandom_range(1, 200));
        5, 6:       den = 16'($urandom_range(1, 65535));
        7:          den = 16'((2 ** $urandom_range(0, 6)) * (5 ** $urandom_range(0, 3)));
        8: begin
          // prime factor with a long period behind a short non-repeating prefix
          case ($urandom_range(0, 5))
            0:       p = 3;
            1:       p = 7;
            2:       p = 13;
            3:       p = 17;
            4:       p = 19;
            default: p = 97;
          endcase
          den = 16'(p << $urandom_range(0, 5));
        end
        default:    den = 16'(65535 - $urandom_range(0, 15));
      endcase
      case ($urandom_range(0, 3))
        0, 1:    num = 16'($urandom_range(0, 65535));
        2:       num = 16'($urandom_range(0, 999));
        default: num = (den == 16'd0) ? 16'hFFFF : den - 16'd1;
      endcase
      send_fraction(num, den);
    end
  endtask

  // Hold off the receiver while requests keep coming, so the input stalls.
  task automatic test_output_backpressure();
    idle_en      = 1'b0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_fraction(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 100)));
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_operands();
    test_repetends();
    test_random_fractions(45, 1'b1);
    test_output_backpressure();
    test_random_fractions(50, 1'b1);
    test_random_fractions(30, 1'b0);
    in_tvalid <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_fraction_to_repeating_decimal_core: clean");
    end else begin
      $display("tb_fraction_to_repeating_decimal_core: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rtdec_pkg.sv
rtl/rtdec_ram.sv
rtl/rtdec_div.sv
rtl/fraction_to_repeating_decimal_core.sv
tb/sv/tb_fraction_to_repeating_decimal_core.sv
